>>> sv/csvtl_pkg.sv
// Shared types and constants for the CSV tile layer decoder.
package csvtl_pkg;

    localparam int ID_WIDTH = 16;
    localparam int MAX_ROWS = 4096;

    localparam int CHAR_W   = 8;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 12;
    localparam int MAPW_W   = 13;
    localparam int TSIZE_W  = 9;
    localparam int COLS_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam int DX_W = 20;
    localparam int DY_W = 20;
    localparam int SX_W = 20;
    localparam int SY_W = 24;

    localparam int OUT_BITS = ID_WIDTH + DX_W + DY_W + SX_W + SY_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int DIV_CNT_W = $clog2(ID_WIDTH);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILESET_COLS = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // Controller to datapath
    typedef struct packed {
        logic take;      // input item accepted this cycle
        logic div_step;  // one quotient bit
        logic mul;       // form pixel products
        logic load;      // move result into output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic launch;    // current char places a nonzero tile
        logic div_last;  // final quotient bit this step
        logic out_free;  // output register can take a result
    } t_dp_sts;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_PUSH = 4'b1000
    } t_state;

endpackage

>>> sv/csvtl_ctrl.sv
// Sequencing state machine for the CSV tile layer decoder.
module csvtl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  csvtl_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output csvtl_pkg::t_dp_cmd o_cmd
);
    import csvtl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_sts.launch) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/csvtl_dp.sv
// Datapath: config registers, number parser, cell counters, divider, products, output register.
module csvtl_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [csvtl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [csvtl_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic [csvtl_pkg::CHAR_W-1:0]       i_char,
    input  logic                               i_out_ready,
    input  csvtl_pkg::t_dp_cmd                 i_cmd,
    output csvtl_pkg::t_dp_sts                 o_sts,
    output logic                               o_out_valid,
    output logic [csvtl_pkg::OUT_W-1:0]        o_out_data
);
    import csvtl_pkg::*;

    // configuration
    logic [MAPW_W-1:0]  r_map_w;
    logic [TSIZE_W-1:0] r_tile_w;
    logic [TSIZE_W-1:0] r_tile_h;
    logic [COLS_W-1:0]  r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w  <= MAPW_W'(1);
            r_tile_w <= TSIZE_W'(16);
            r_tile_h <= TSIZE_W'(16);
            r_cols   <= COLS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:    r_map_w  <= i_cfg_data;
                CFG_TILE_WIDTH:   r_tile_w <= i_cfg_data[TSIZE_W-1:0];
                CFG_TILE_HEIGHT:  r_tile_h <= i_cfg_data[TSIZE_W-1:0];
                CFG_TILESET_COLS: r_cols   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to legal ranges
    logic [MAPW_W-1:0]  mw_c;
    logic [TSIZE_W-1:0] tw_c;
    logic [TSIZE_W-1:0] th_c;
    logic [COLS_W-1:0]  cols_c;

    always_comb begin
        if (r_map_w == '0)                    mw_c = MAPW_W'(1);
        else if (r_map_w > MAPW_W'(4096))     mw_c = MAPW_W'(4096);
        else                                  mw_c = r_map_w;
        if (r_cols == '0)                     cols_c = COLS_W'(1);
        else if (r_cols > COLS_W'(4096))      cols_c = COLS_W'(4096);
        else                                  cols_c = r_cols;
        if (r_tile_w == '0)                   tw_c = TSIZE_W'(1);
        else if (r_tile_w > TSIZE_W'(256))    tw_c = TSIZE_W'(256);
        else                                  tw_c = r_tile_w;
        if (r_tile_h == '0)                   th_c = TSIZE_W'(1);
        else if (r_tile_h > TSIZE_W'(256))    th_c = TSIZE_W'(256);
        else                                  th_c = r_tile_h;
    end

    // parser and cell position
    logic [ID_WIDTH-1:0] r_acc;
    logic                r_seen;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;

    logic is_nul, is_digit, places;
    logic [ID_WIDTH+3:0] acc_x10;
    logic [ID_WIDTH-1:0] acc_sat;
    logic [COL_W:0]      col_inc;

    always_comb begin
        is_nul   = (i_char == CHAR_NUL);
        is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        places   = !is_nul && !is_digit && r_seen;
        acc_x10  = ({4'b0, r_acc} * (ID_WIDTH+4)'(10))
                 + (ID_WIDTH+4)'(i_char - CHAR_ZERO);
        acc_sat  = (acc_x10[ID_WIDTH+3:ID_WIDTH] != '0) ? '1 : acc_x10[ID_WIDTH-1:0];
        col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_seen <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cmd.take) begin
            if (is_nul) begin
                r_acc  <= '0;
                r_seen <= 1'b0;
                r_col  <= '0;
                r_row  <= '0;
            end else if (is_digit) begin
                r_acc  <= acc_sat;
                r_seen <= 1'b1;
            end else if (r_seen) begin
                r_acc  <= '0;
                r_seen <= 1'b0;
                if (col_inc >= mw_c) begin
                    r_col <= '0;
                    if (r_row != ROW_W'(MAX_ROWS - 1)) begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end
        end
    end

    // work registers: captured tile, restoring divider
    logic [ID_WIDTH-1:0]  r_tile;
    logic [COL_W-1:0]     r_wcol;
    logic [ROW_W-1:0]     r_wrow;
    logic [ID_WIDTH-1:0]  r_quo;
    logic [COLS_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic [COLS_W:0]   trial;
    logic              trial_ge;
    logic [COLS_W:0]   trial_sub;

    always_comb begin
        trial     = {r_rem, r_quo[ID_WIDTH-1]};
        trial_ge  = trial >= {1'b0, cols_c};
        trial_sub = trial - {1'b0, cols_c};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && places) begin
            r_tile <= r_acc;
            r_wcol <= r_col;
            r_wrow <= r_row;
            r_quo  <= r_acc - ID_WIDTH'(1);
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? trial_sub[COLS_W-1:0] : trial[COLS_W-1:0];
            r_quo  <= {r_quo[ID_WIDTH-2:0], trial_ge};
            r_cnt  <= r_cnt + DIV_CNT_W'(1);
        end
    end

    // pixel products, one small multiplier each
    logic [COL_W+TSIZE_W-1:0]    p_dx;
    logic [ROW_W+TSIZE_W-1:0]    p_dy;
    logic [COLS_W+TSIZE_W-1:0]   p_sx;
    logic [ID_WIDTH+TSIZE_W-1:0] p_sy;

    always_comb begin
        p_dx = {{TSIZE_W{1'b0}}, r_wcol} * {{COL_W{1'b0}}, tw_c};
        p_dy = {{TSIZE_W{1'b0}}, r_wrow} * {{ROW_W{1'b0}}, th_c};
        p_sx = {{TSIZE_W{1'b0}}, r_rem}  * {{COLS_W{1'b0}}, tw_c};
        p_sy = {{TSIZE_W{1'b0}}, r_quo}  * {{ID_WIDTH{1'b0}}, th_c};
    end

    logic [DX_W-1:0] r_dx;
    logic [DY_W-1:0] r_dy;
    logic [SX_W-1:0] r_sx;
    logic [SY_W-1:0] r_sy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dx <= p_dx[DX_W-1:0];
            r_dy <= p_dy[DY_W-1:0];
            r_sx <= p_sx[SX_W-1:0];
            r_sy <= p_sy[SY_W-1:0];
        end
    end

    // output register
    logic r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= {(OUT_W-OUT_BITS)'(0), r_sy, r_sx, r_dy, r_dx, r_tile};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_sts.launch    = places && (r_acc != '0);
    assign o_sts.div_last  = (r_cnt == DIV_CNT_W'(ID_WIDTH - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

>>> sv/csv_tile_layer_decoder.sv
// Top level of the CSV tile layer decoder: controller, datapath and checks.
//
//  channel   dir  handshake                     payload (low bit first)
//  s_axis    in   s_axis_tvalid/s_axis_tready   char_code[7:0]
//  m_axis    out  m_axis_tvalid/m_axis_tready   tile_id, dest_x, dest_y, src_x, src_y, pad
//  cfg       in   i_cfg_we (no wait)            i_cfg_index selects, i_cfg_data value
//
// Digits, NUL, separators with no number pending and separators ending a tile
// number of zero are taken in the idle state. A separator that places a nonzero
// tile is captured, then takes 16 steps of the bit-serial divider (one quotient
// bit per cycle), a product step and a load into the output register; that load
// waits while a previous item is still held on m_axis. Input is accepted again
// as soon as the result is loaded. Reset is synchronous, active low, and clears
// parser, cell counters and control; config registers return to their defaults.
module csv_tile_layer_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csvtl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [csvtl_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [csvtl_pkg::CHAR_W-1:0]      s_axis_tdata,  // char_code[7:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tile_id[15:0], dest_x[35:16], dest_y[55:36], src_x[75:56], src_y[99:76], zero pad
    output logic [csvtl_pkg::OUT_W-1:0]       m_axis_tdata
);
    import csvtl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    csvtl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    csvtl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // a result is never loaded over one still waiting on m_axis
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a held item");

    // at most one datapath action per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take, cmd.div_step, cmd.mul, cmd.load}))
        else $error("overlapping datapath commands");

    // while a tile is being worked, no input is taken
    a_busy_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mul |=> !s_axis_tready)
        else $error("input accepted before result loaded");

    // a load always presents a result in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule
